FILE: rtl/core/sem_pkg.sv
package sem_pkg;

    // Field widths
    localparam int PIXEL_W      = 8;
    localparam int COORD_W      = 10;
    localparam int MAG_W        = 8;
    localparam int LINE_WIDTH_W = 11;

    // Configuration
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = LINE_WIDTH_W'(640);
    localparam int MIN_LINE_WIDTH = 3;

    // Default geometry limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Gradient and magnitude arithmetic
    localparam int GRAD_W      = 11;                   // signed, |g| <= 1020
    localparam int SQ_W        = 20;                   // g*g <= 1040400
    localparam int SUM_W       = SQ_W + 1;
    localparam int SCALE_SHIFT = 6;                    // times 64
    localparam int VAL_W       = SUM_W + SCALE_SHIFT;
    localparam int DIVISOR     = 25;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 28;
    localparam logic [RECIP_W-1:0] RECIP_25 =
        RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
    localparam int QUO_W       = 23;                   // 64*sum/25 < 2**23
    localparam int ROOT_IN_W   = 2 * MAG_W;            // radicand below the clamp
    localparam int MAG_MAX     = 255;

    // Square root pipeline
    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES     = MAG_W / STEPS_PER_STAGE;

    // 3x3 window, [row 0 top][column 0 left]
    typedef logic [2:0][2:0][PIXEL_W-1:0] t_window;

    // Tag that travels with each pipeline stage
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_tag;

    // One result item
    typedef struct packed {
        logic [MAG_W-1:0]   mag;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_result;

endpackage

FILE: rtl/core/sem_ifs.sv
interface sem_pix_if import sem_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] gray_pixel;
    logic               frame_start;

    modport source (output valid, output gray_pixel, output frame_start, input ready);
    modport sink   (input valid, input gray_pixel, input frame_start, output ready);
endinterface

interface sem_res_if import sem_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MAG_W-1:0]   edge_magnitude;
    logic [COORD_W-1:0] centre_column;
    logic [COORD_W-1:0] centre_row;

    modport source (output valid, output edge_magnitude, output centre_column,
                    output centre_row, input ready);
    modport sink   (input valid, input edge_magnitude, input centre_column,
                    input centre_row, output ready);
endinterface

interface sem_cfg_if import sem_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [LINE_WIDTH_W-1:0] line_width;

    modport source (output valid, output line_width, input ready);
    modport sink   (input valid, input line_width, output ready);
endinterface

FILE: rtl/core/sem_lbuf.sv
module sem_lbuf import sem_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [PIXEL_W-1:0]      i_gray_pixel,
    input  logic                    i_frame_start,
    input  logic [LINE_WIDTH_W-1:0] i_line_width,
    output t_window                 o_window,
    output t_tag                    o_tag
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CW = (AW + 1 > LINE_WIDTH_W) ? AW + 1 : LINE_WIDTH_W;
    localparam int LW = 2 * PIXEL_W;

    logic [AW-1:0] r_col, n_col, w_x;
    logic [RW-1:0] r_row, n_row, w_y;
    logic [CW-1:0] w_lw, w_width, w_next_x;
    logic          w_acc, w_wr, w_emit;

    // Line store: {upper, middle} per column
    logic [LW-1:0] r_mem [MAX_WIDTH];
    logic [LW-1:0] r_rd, w_old, w_new;

    // Most recent line store write, for read-after-write forwarding
    logic          r_fw_valid;
    logic [AW-1:0] r_fw_addr;
    logic [LW-1:0] r_fw_data;

    // Stage 1
    logic               r_s1_valid, r_s1_emit;
    logic [AW-1:0]      r_s1_x;
    logic [PIXEL_W-1:0] r_s1_pix;
    logic [COORD_W-1:0] r_s1_col, r_s1_row;

    // Stage 2
    t_window r_win;
    t_tag    r_tag;

    assign w_acc = i_en & i_valid;
    assign w_wr  = i_en & r_s1_valid;

    always_comb begin
        w_x = i_frame_start ? '0 : r_col;
        w_y = i_frame_start ? '0 : r_row;
        w_lw = CW'(i_line_width);
        if (w_lw < CW'(MIN_LINE_WIDTH)) begin
            w_width = CW'(MIN_LINE_WIDTH);
        end else if (w_lw > CW'(MAX_WIDTH)) begin
            w_width = CW'(MAX_WIDTH);
        end else begin
            w_width = w_lw;
        end
        w_next_x = CW'(w_x) + CW'(1);
        if (w_next_x >= w_width) begin
            n_col = '0;
            n_row = (w_y < RW'(MAX_HEIGHT - 1)) ? w_y + RW'(1) : w_y;
        end else begin
            n_col = w_next_x[AW-1:0];
            n_row = w_y;
        end
        w_emit = (w_y >= RW'(2)) && (w_x >= AW'(2));
    end

    always_comb begin
        w_old = (r_fw_valid && (r_fw_addr == r_s1_x)) ? r_fw_data : r_rd;
        w_new = {w_old[PIXEL_W-1:0], r_s1_pix};
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd <= r_mem[w_x];
        end
        if (w_wr) begin
            r_mem[r_s1_x] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_fw_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_tag      <= '0;
            r_win      <= '0;
        end else begin
            if (w_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (w_wr) begin
                r_fw_valid <= 1'b1;
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= w_old[LW-1:PIXEL_W];
                r_win[1][2] <= w_old[PIXEL_W-1:0];
                r_win[2][2] <= r_s1_pix;
            end
            if (i_en) begin
                r_s1_valid <= i_valid;
                r_tag      <= '{valid: r_s1_valid & r_s1_emit, col: r_s1_col, row: r_s1_row};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_fw_addr <= r_s1_x;
            r_fw_data <= w_new;
        end
        if (w_acc) begin
            r_s1_x    <= w_x;
            r_s1_pix  <= i_gray_pixel;
            r_s1_emit <= w_emit;
            r_s1_col  <= COORD_W'(w_x - AW'(1));
            r_s1_row  <= COORD_W'(w_y - RW'(1));
        end
    end

    assign o_window = r_win;
    assign o_tag    = r_tag;

endmodule

FILE: rtl/core/sem_grad.sv
module sem_grad import sem_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_window          i_window,
    input  t_tag             i_tag,
    output logic [SUM_W-1:0] o_sum,
    output t_tag             o_tag
);

    function automatic logic signed [GRAD_W-1:0] px(input logic [PIXEL_W-1:0] p);
        return $signed(GRAD_W'(p));
    endfunction

    logic signed [GRAD_W-1:0]   w_gx, w_gy, r_gx, r_gy;
    logic signed [2*GRAD_W-1:0] w_gx2, w_gy2;
    logic [SQ_W-1:0]            r_sqx, r_sqy;
    logic [SUM_W-1:0]           r_sum;
    t_tag                       r_tag3, r_tag4, r_tag5;

    always_comb begin
        w_gx = (px(i_window[0][2]) + (px(i_window[1][2]) <<< 1) + px(i_window[2][2]))
             - (px(i_window[0][0]) + (px(i_window[1][0]) <<< 1) + px(i_window[2][0]));
        w_gy = (px(i_window[2][0]) + (px(i_window[2][1]) <<< 1) + px(i_window[2][2]))
             - (px(i_window[0][0]) + (px(i_window[0][1]) <<< 1) + px(i_window[0][2]));
        w_gx2 = (2*GRAD_W)'(r_gx) * (2*GRAD_W)'(r_gx);
        w_gy2 = (2*GRAD_W)'(r_gy) * (2*GRAD_W)'(r_gy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag3 <= '0;
            r_tag4 <= '0;
            r_tag5 <= '0;
        end else if (i_en) begin
            r_tag3 <= i_tag;
            r_tag4 <= r_tag3;
            r_tag5 <= r_tag4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gx  <= w_gx;
            r_gy  <= w_gy;
            r_sqx <= w_gx2[SQ_W-1:0];
            r_sqy <= w_gy2[SQ_W-1:0];
            r_sum <= SUM_W'(r_sqx) + SUM_W'(r_sqy);
        end
    end

    assign o_sum = r_sum;
    assign o_tag = r_tag5;

endmodule

FILE: rtl/core/sem_scale.sv
module sem_scale import sem_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [SUM_W-1:0]     i_sum,
    input  t_tag                 i_tag,
    output logic [ROOT_IN_W-1:0] o_q,
    output logic                 o_over,
    output t_tag                 o_tag
);

    logic [VAL_W-1:0]         w_v, r_v, w_rem;
    logic [VAL_W+RECIP_W-1:0] w_prod, r_prod;
    logic [QUO_W-1:0]         w_qe, w_q;
    logic [ROOT_IN_W-1:0]     r_q;
    logic                     r_over;
    t_tag                     r_tag6, r_tag7;

    always_comb begin
        w_v    = {i_sum, {SCALE_SHIFT{1'b0}}};
        w_prod = (VAL_W+RECIP_W)'(w_v) * (VAL_W+RECIP_W)'(RECIP_25);
        // Reciprocal estimate is low by at most one; fix with one compare
        w_qe   = r_prod[RECIP_SHIFT +: QUO_W];
        w_rem  = r_v - VAL_W'(w_qe) * VAL_W'(DIVISOR);
        w_q    = (w_rem >= VAL_W'(DIVISOR)) ? w_qe + QUO_W'(1) : w_qe;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag6 <= '0;
            r_tag7 <= '0;
        end else if (i_en) begin
            r_tag6 <= i_tag;
            r_tag7 <= r_tag6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= w_v;
            r_prod <= w_prod;
            r_q    <= w_q[ROOT_IN_W-1:0];
            r_over <= |w_q[QUO_W-1:ROOT_IN_W];
        end
    end

    assign o_q    = r_q;
    assign o_over = r_over;
    assign o_tag  = r_tag7;

endmodule

FILE: rtl/core/sem_sqrt.sv
module sem_sqrt import sem_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [ROOT_IN_W-1:0] i_q,
    input  logic                 i_over,
    input  t_tag                 i_tag,
    output logic [MAG_W-1:0]     o_mag,
    output t_tag                 o_tag
);

    localparam int REM_W = MAG_W + 2;
    localparam int RSH_W = REM_W + 2;
    localparam int LAST  = SQRT_STAGES - 1;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] root;
    } t_sq_st;

    function automatic t_sq_st sq_step(input t_sq_st s, input logic [1:0] pair);
        logic [RSH_W-1:0] rsh;
        logic [RSH_W-1:0] trial;
        t_sq_st           o;
        rsh   = {s.rem, pair};
        trial = RSH_W'({s.root, 2'b01});
        if (rsh >= trial) begin
            o.rem  = REM_W'(rsh - trial);
            o.root = {s.root[MAG_W-2:0], 1'b1};
        end else begin
            o.rem  = REM_W'(rsh);
            o.root = {s.root[MAG_W-2:0], 1'b0};
        end
        return o;
    endfunction

    logic [REM_W-1:0]     r_rem  [SQRT_STAGES];
    logic [MAG_W-1:0]     r_root [SQRT_STAGES];
    logic [ROOT_IN_W-1:0] r_rad  [SQRT_STAGES];
    logic                 r_over [SQRT_STAGES];
    t_tag                 r_tag  [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        localparam int HI = ROOT_IN_W - 1 - 2 * STEPS_PER_STAGE * s;

        t_sq_st               w_in, w_mid, w_out;
        logic [ROOT_IN_W-1:0] w_rad;
        logic                 w_ov;
        t_tag                 w_tag;

        if (s == 0) begin : g_first
            assign w_in  = '0;
            assign w_rad = i_q;
            assign w_ov  = i_over;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_in  = '{rem: r_rem[s-1], root: r_root[s-1]};
            assign w_rad = r_rad[s-1];
            assign w_ov  = r_over[s-1];
            assign w_tag = r_tag[s-1];
        end

        // Two radicand bit pairs per stage
        assign w_mid = sq_step(w_in, w_rad[HI -: 2]);
        assign w_out = sq_step(w_mid, w_rad[HI-2 -: 2]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else if (i_en) begin
                r_tag[s] <= w_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_out.rem;
                r_root[s] <= w_out.root;
                r_rad[s]  <= w_rad;
                r_over[s] <= w_ov;
            end
        end
    end

    assign o_mag = r_over[LAST] ? MAG_W'(MAG_MAX) : r_root[LAST];
    assign o_tag = r_tag[LAST];

endmodule

FILE: rtl/core/sobel_edge_magnitude_core.sv
// Sobel 3x3 edge magnitude on a raster stream of 8-bit gray pixels.
//
// i_pix carries one pixel per transfer in raster order; frame_start marks
// the first pixel of a frame and puts it at column 0, row 0. i_cfg writes
// line_width (pixels per row, taken as 3..MAX_WIDTH); it is always ready.
// The user must ensure it is written only while the stream is idle; the
// block does not enforce this. o_res gives one transfer per interior
// pixel: the window centre's gradient magnitude times 1.6, clamped to
// 255, with its column and row. Border pixels give nothing.
// Throughput: one pixel per cycle while the output buffer has room. A
// result passes through the stage chain (line store read, window,
// gradient, squares, sum, reciprocal multiply, correction, four square
// root stages of two bits each) and a two-entry output buffer to o_res.
//
// Reset clears counters, window, valid bits and line_width (back to 640).
// Line store contents are undefined until written. When the receiver
// stalls, the output buffer absorbs one more result; once both entries are
// full the whole pipeline holds and i_pix.ready drops.
module sobel_edge_magnitude_core import sem_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sem_pix_if.sink   i_pix,
    sem_cfg_if.sink   i_cfg,
    sem_res_if.source o_res
);

    logic [LINE_WIDTH_W-1:0] r_line_width;

    logic                 w_en;
    t_window              w_window;
    t_tag                 w_tag_win, w_tag_sum, w_tag_q, w_tag_mag;
    logic [SUM_W-1:0]     w_sum;
    logic [ROOT_IN_W-1:0] w_q;
    logic                 w_over;
    logic [MAG_W-1:0]     w_mag;

    // Output buffer: head drives o_res, skid holds one extra result
    t_result r_head, r_skid, w_push_data;
    logic    r_head_valid, r_skid_valid;
    logic    w_push, w_pop;

    // Pipeline advances whenever the skid entry is free
    assign w_en        = ~r_skid_valid;
    assign i_pix.ready = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
        end else if (i_cfg.valid) begin
            r_line_width <= i_cfg.line_width;
        end
    end

    sem_lbuf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_lbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_pix.valid),
        .i_gray_pixel  (i_pix.gray_pixel),
        .i_frame_start (i_pix.frame_start),
        .i_line_width  (r_line_width),
        .o_window      (w_window),
        .o_tag         (w_tag_win)
    );

    sem_grad u_grad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_window (w_window),
        .i_tag    (w_tag_win),
        .o_sum    (w_sum),
        .o_tag    (w_tag_sum)
    );

    sem_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_sum   (w_sum),
        .i_tag   (w_tag_sum),
        .o_q     (w_q),
        .o_over  (w_over),
        .o_tag   (w_tag_q)
    );

    sem_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_q     (w_q),
        .i_over  (w_over),
        .i_tag   (w_tag_q),
        .o_mag   (w_mag),
        .o_tag   (w_tag_mag)
    );

    assign w_push      = w_en & w_tag_mag.valid;
    assign w_pop       = r_head_valid & o_res.ready;
    assign w_push_data = '{mag: w_mag, col: w_tag_mag.col, row: w_tag_mag.row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_pop || !r_head_valid) begin
                // Refill head from skid first, else from the pipeline
                if (r_skid_valid) begin
                    r_head_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_head_valid <= w_push;
                end
            end else if (w_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop || !r_head_valid) begin
            r_head <= r_skid_valid ? r_skid : w_push_data;
        end else if (w_push) begin
            r_skid <= w_push_data;
        end
    end

    assign o_res.valid          = r_head_valid;
    assign o_res.edge_magnitude = r_head.mag;
    assign o_res.centre_column  = r_head.col;
    assign o_res.centre_row     = r_head.row;

endmodule

FILE: test/tb.sv
module tb;
    import sem_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 16;    // pixel-to-result latency plus margin
    localparam int HOLD_CYCLES   = 80;    // long receiver hold-off, well past pipeline depth
    localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer before giving up
    localparam int GENERIC_ITEMS = 1300;
    localparam int LAST_ROW      = DEF_MAX_HEIGHT - 1;

    // Content style of one frame: white noise, slow ramps (small and zero
    // gradients), or hard black/white (clamped gradients).
    typedef enum int {TEX_NOISE, TEX_SMOOTH, TEX_BINARY} t_texture;

    // Tracks the line stores, window and counters of the block and keeps the
    // edge results that the accepted pixels call for, oldest first.
    class sobel_scoreboard;
        int                      upper_row [DEF_MAX_WIDTH];
        int                      middle_row [DEF_MAX_WIDTH];
        int                      win [3][3];   // [row 0 top][column 0 left]
        int                      col_pos;
        int                      row_pos;
        logic [LINE_WIDTH_W-1:0] line_width;
        t_result                 expected_edges [$];
        int                      errors;

        function new();
            for (int k = 0; k < DEF_MAX_WIDTH; k++) begin
                upper_row[k]  = 0;
                middle_row[k] = 0;
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) win[r][c] = 0;
            end
            col_pos    = 0;
            row_pos    = 0;
            line_width = LINE_WIDTH_RESET;
            errors     = 0;
        endfunction

        function void set_line_width(logic [LINE_WIDTH_W-1:0] value);
            line_width = value;
        endfunction

        function int pending();
            return expected_edges.size();
        endfunction

        // Gradient magnitude times 1.6 as isqrt(64*(gx^2+gy^2)/25), clamped.
        function logic [MAG_W-1:0] window_magnitude();
            int gx, gy, radicand, root, trial;
            gx = (win[0][2] + 2 * win[1][2] + win[2][2])
               - (win[0][0] + 2 * win[1][0] + win[2][0]);
            gy = (win[2][0] + 2 * win[2][1] + win[2][2])
               - (win[0][0] + 2 * win[0][1] + win[0][2]);
            radicand = ((gx * gx + gy * gy) * 64) / 25;
            if (radicand >= 65536) return MAG_W'(MAG_MAX);
            root = 0;
            for (int b = MAG_W - 1; b >= 0; b--) begin
                trial = root | (1 << b);
                if (trial * trial <= radicand) root = trial;
            end
            return MAG_W'(root);
        endfunction

        function void take_pixel(logic [PIXEL_W-1:0] pix, logic frame_start);
            int      span, x, y;
            t_result edge_item;
            span = int'(line_width);
            if (span < MIN_LINE_WIDTH) span = MIN_LINE_WIDTH;
            if (span > DEF_MAX_WIDTH) span = DEF_MAX_WIDTH;
            if (frame_start) begin
                col_pos = 0;
                row_pos = 0;
            end
            x = col_pos;
            y = row_pos;
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2]     = upper_row[x];
            win[1][2]     = middle_row[x];
            win[2][2]     = int'(pix);
            upper_row[x]  = middle_row[x];
            middle_row[x] = int'(pix);
            if (y >= 2 && x >= 2) begin
                edge_item.mag = window_magnitude();
                edge_item.col = COORD_W'(x - 1);
                edge_item.row = COORD_W'(y - 1);
                expected_edges.push_back(edge_item);
            end
            x++;
            if (x >= span) begin
                x = 0;
                if (y < LAST_ROW) y++;
            end
            col_pos = x;
            row_pos = y;
        endfunction

        function void check_result(logic [MAG_W-1:0] mag, logic [COORD_W-1:0] col,
                                   logic [COORD_W-1:0] row);
            t_result want;
            if (expected_edges.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual mag %0d col %0d row %0d",
                         $time, mag, col, row);
                errors++;
                return;
            end
            want = expected_edges.pop_front();
            if (mag !== want.mag) begin
                $display("%0t: edge_magnitude mismatch at col %0d row %0d, expected %0d, actual %0d",
                         $time, want.col, want.row, want.mag, mag);
                errors++;
            end
            if (col !== want.col) begin
                $display("%0t: centre_column mismatch, expected %0d, actual %0d",
                         $time, want.col, col);
                errors++;
            end
            if (row !== want.row) begin
                $display("%0t: centre_row mismatch, expected %0d, actual %0d",
                         $time, want.row, row);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sem_pix_if pix_if ();
    sem_cfg_if cfg_if ();
    sem_res_if res_if ();

    sobel_edge_magnitude_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    sobel_scoreboard sb;

    // Idle percentages for the pixel sender and the result receiver; zero
    // means a stretch with no idling on that side.
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    bit hold_request = 1'b0;
    int stall_left   = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Monitor every channel on the rising edge. Inputs change only through
    // nonblocking updates at that edge, so the sampled values are the ones
    // the block saw. Also run the watchdog on transfers of any kind.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready) sb.set_line_width(cfg_if.line_width);
            if (pix_if.valid && pix_if.ready) sb.take_pixel(pix_if.gray_pixel, pix_if.frame_start);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.edge_magnitude, res_if.centre_column, res_if.centre_row);
            if ((cfg_if.valid && cfg_if.ready) || (pix_if.valid && pix_if.ready) ||
                (res_if.valid && res_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result receiver. Drop ready in random bursts, or hold it low for a
    // long stretch once asked to and a result is waiting, so the output
    // buffer fills and the block stalls its pixel input.
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_request && res_if.valid) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 6) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Offer one pixel, possibly after a random gap, and hold it until its
    // transfer. Valid stays high afterwards so back-to-back pixels stream.
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input bit start);
        int gap;
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 6);
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.gray_pixel  <= pix;
        pix_if.frame_start <= start;
        do @(posedge clk); while (!pix_if.ready);
    endtask

    // Stream count pixels of one texture. Flag the first as a frame start if
    // asked; at pause_at, drop valid and wait until every result is out.
    task automatic send_frame(input int count, input bit with_start, input int pause_at);
        t_texture           tex;
        int                 level;
        logic [PIXEL_W-1:0] pix;
        tex   = t_texture'($urandom_range(0, 2));
        level = $urandom_range(0, 255);
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) begin
                pix_if.valid <= 1'b0;
                do @(posedge clk); while (sb.pending() != 0);
            end
            case (tex)
                TEX_NOISE: begin
                    pix = PIXEL_W'($urandom_range(0, 255));
                end
                TEX_SMOOTH: begin
                    level += int'($urandom_range(0, 4)) - 2;
                    if (level < 0) level = 0;
                    if (level > 255) level = 255;
                    pix = PIXEL_W'(level);
                end
                default: begin
                    pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
            endcase
            send_pixel(pix, with_start && k == 0);
        end
    endtask

    // Drop valid, wait for every expected result, then let border pixels
    // that give no result drain through the pipeline.
    task automatic settle();
        pix_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_line_width(input logic [LINE_WIDTH_W-1:0] value);
        cfg_if.valid      <= 1'b1;
        cfg_if.line_width <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        logic [LINE_WIDTH_W-1:0] width_value;
        logic [PIXEL_W-1:0]      directed [22];
        int                      span;
        int                      count;
        int                      generic_items;
        bit                      with_start;

        sb = new();
        rst_n              <= 1'b0;
        pix_if.valid       <= 1'b0;
        pix_if.gray_pixel  <= '0;
        pix_if.frame_start <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.line_width  <= '0;
        res_if.ready       <= 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the narrowest width. Frame A: a black-to-white
        // vertical edge (clamped to 255), then a white row, cut off one
        // pixel into its last row. Frame B starts mid-row: a flat gray
        // patch with one slightly brighter corner, a small magnitude.
        directed = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255,
                     8'd255, 8'd255, 8'd255, 8'd255,
                     8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd80};
        settle();
        write_line_width(LINE_WIDTH_W'(MIN_LINE_WIDTH));
        for (int k = 0; k < 22; k++) send_pixel(directed[k], k == 0 || k == 13);

        // Long receiver hold-off with the sender streaming at full rate.
        settle();
        write_line_width(LINE_WIDTH_W'(16));
        hold_request = 1'b1;
        send_frame(6 * 16, 1'b1, -1);

        // Sender pauses mid-frame until every result has arrived.
        settle();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        write_line_width(LINE_WIDTH_W'(12));
        send_frame(5 * 12 + 5, 1'b1, 40);

        // Narrow the line mid-frame; the counters carry on without a frame
        // start and the next column comparison wraps at the new width.
        settle();
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        write_line_width(LINE_WIDTH_W'(20));
        send_frame(3 * 20 + 7, 1'b1, -1);
        settle();
        write_line_width(LINE_WIDTH_W'(6));
        send_frame(4 * 6 + 2, 1'b0, -1);
        span = 6;

        // Random frames, mostly narrow lines; some continue the running
        // frame without a frame start when the width stays the same.
        generic_items = 0;
        while (generic_items < GENERIC_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 10;
                default: tx_idle_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_idle_pct = 0;
                1:       rx_idle_pct = 10;
                default: rx_idle_pct = 35;
            endcase
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0:       width_value = LINE_WIDTH_W'($urandom_range(0, MIN_LINE_WIDTH - 1));
                    1:       width_value = LINE_WIDTH_W'($urandom_range(25, 80));
                    default: width_value = LINE_WIDTH_W'($urandom_range(MIN_LINE_WIDTH, 24));
                endcase
                settle();
                write_line_width(width_value);
                span       = (int'(width_value) < MIN_LINE_WIDTH) ? MIN_LINE_WIDTH
                                                                  : int'(width_value);
                with_start = 1'b1;
            end else begin
                with_start = $urandom_range(0, 3) != 0;
            end
            if (span > 40) count = 3 * span + $urandom_range(0, span - 1);
            else count = $urandom_range(3, 6) * span + $urandom_range(0, span - 1);
            send_frame(count, with_start, -1);
            generic_items += count;
        end

        // Closing stretch with no idling on either side.
        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        width_value = LINE_WIDTH_W'($urandom_range(MIN_LINE_WIDTH, 12));
        write_line_width(width_value);
        send_frame(5 * int'(width_value) + 3, 1'b1, -1);
        send_frame(4 * int'(width_value), 1'b1, -1);

        settle();
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sem_pkg.sv
rtl/core/sem_ifs.sv
rtl/core/sem_lbuf.sv
rtl/core/sem_grad.sv
rtl/core/sem_scale.sv
rtl/core/sem_sqrt.sv
rtl/core/sobel_edge_magnitude_core.sv
test/tb.sv
